// ----- rtl/lmd_pkg.sv -----
`default_nettype none
package lmd_pkg;

	localparam int N_SLOTS   = 16;
	localparam int N_ENTRIES = 64;
	localparam int SLOT_W    = $clog2(N_SLOTS);
	localparam int PASS_W    = $clog2(N_SLOTS);

	typedef enum logic [2:0] {
		ACT_BEGIN    = 3'd0,
		ACT_COMMIT   = 3'd1,
		ACT_ROLLBACK = 3'd2,
		ACT_ACQUIRE  = 3'd3,
		ACT_RELEASE  = 3'd4,
		ACT_DEADLOCK = 3'd5,
		ACT_QUERY    = 3'd6,
		ACT_NONE     = 3'd7
	} action_t;

	localparam logic [2:0] STS_OK         = 3'd0;
	localparam logic [2:0] STS_NOT_FOUND  = 3'd1;
	localparam logic [2:0] STS_NOT_ACTIVE = 3'd2;
	localparam logic [2:0] STS_CONFLICT   = 3'd3;
	localparam logic [2:0] STS_FULL       = 3'd4;

	localparam logic [1:0] TS_ACTIVE    = 2'd0;
	localparam logic [1:0] TS_COMMITTED = 2'd1;
	localparam logic [1:0] TS_ABORTED   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_COMPACT,
		ST_PEEL
	} fsm_t;

	typedef struct packed {
		logic              valid;
		logic [31:0]       res;
		logic [SLOT_W-1:0] holder;
		logic              excl;
	} entry_t;

	typedef struct packed {
		logic               drop;
		logic               by_key;
		logic               shift;
		logic               append;
		logic [31:0]        key;
		logic [N_SLOTS-1:0] slot_mask;
		logic [SLOT_W-1:0]  slot;
		logic               excl;
	} cmd_t;

endpackage
`default_nettype wire

// ----- rtl/lock_manager_with_deadlock_check_top.sv -----
`default_nettype none
// Lock manager with deadlock check. A request is taken when start is high and busy is low;
// its single result appears in the cycle after it finishes, marked by a one-cycle done strobe,
// and cannot be held off. Begin, acquire and query finish from the execute state. Commit and
// rollback of an active transaction, and release, then compact the lock table, which is a row
// of cells that closes one gap per cycle until no gap is left.
// A deadlock check makes 16 peeling passes over the wait-for matrix.
module lock_manager_with_deadlock_check_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  action,
	input  wire logic [31:0] txn_id,
	input  wire logic [31:0] resource_key,
	input  wire logic        lock_exclusive,
	output logic             done,
	output logic             accepted,
	output logic [2:0]       status,
	output logic [31:0]      new_txn_id,
	output logic [1:0]       txn_state,
	output logic             deadlock
);
	import lmd_pkg::*;

	fsm_t                state_q, state_d;
	action_t             act_q;
	logic [31:0]         id_q, key_q;
	logic                excl_q;
	logic [N_SLOTS-1:0]  used_q;
	logic [31:0]         sid_q   [N_SLOTS];
	logic [1:0]          sst_q   [N_SLOTS];
	logic [N_SLOTS-1:0]  wait_q  [N_SLOTS];
	logic [31:0]         ctr_q;
	logic [N_SLOTS-1:0]  alive_q;
	logic [PASS_W-1:0]   pass_q;
	logic                done_q, acc_q, dead_q;
	logic [2:0]          sts_q;
	logic [31:0]         nid_q;
	logic [1:0]          tst_q;

	logic [N_SLOTS-1:0]  hit_vec, free_vec, incoming, alive_nx;
	logic                found, any_free, active;
	logic [SLOT_W-1:0]   s_idx, f_idx;
	cmd_t                cmd;
	logic                conf_any, full, holes, exec, fin, fixing;
	logic [SLOT_W-1:0]   conf_holder;

	lmd_chain u_chain (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.conf_any    (conf_any),
		.conf_holder (conf_holder),
		.full        (full),
		.holes       (holes)
	);

	always_comb begin
		found    = 1'b0;
		any_free = 1'b0;
		s_idx    = '0;
		f_idx    = '0;
		incoming = '0;
		for (int s = N_SLOTS - 1; s >= 0; s--) begin
			hit_vec[s]  = used_q[s] && (sid_q[s] == id_q);
			free_vec[s] = !used_q[s] || (sst_q[s] != TS_ACTIVE);
			if (hit_vec[s]) begin
				found = 1'b1;
				s_idx = SLOT_W'(s);
			end
			if (free_vec[s]) begin
				any_free = 1'b1;
				f_idx    = SLOT_W'(s);
			end
			if (alive_q[s]) begin
				incoming = incoming | wait_q[s];
			end
		end
		active   = found && (sst_q[s_idx] == TS_ACTIVE);
		alive_nx = alive_q & incoming;
	end

	assign exec   = state_q == ST_EXEC;
	assign fixing = ((act_q == ACT_COMMIT || act_q == ACT_ROLLBACK) && active)
		|| act_q == ACT_RELEASE;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (start) state_d = ST_EXEC;
			ST_EXEC: begin
				if (act_q == ACT_DEADLOCK) state_d = ST_PEEL;
				else if (fixing) state_d = ST_COMPACT;
				else state_d = ST_IDLE;
			end
			ST_COMPACT: if (!holes) state_d = ST_IDLE;
			ST_PEEL:    if (pass_q == PASS_W'(N_SLOTS - 1)) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy          = state_q != ST_IDLE;
		fin           = 1'b0;
		cmd           = '0;
		cmd.key       = key_q;
		cmd.slot      = s_idx;
		cmd.excl      = excl_q;
		cmd.by_key    = act_q == ACT_RELEASE;
		cmd.slot_mask = (act_q == ACT_RELEASE) ? hit_vec : (N_SLOTS'(1) << s_idx);
		case (state_q)
			ST_EXEC: begin
				cmd.drop   = fixing;
				cmd.append = act_q == ACT_ACQUIRE && active && !conf_any && !full;
				fin        = act_q != ACT_DEADLOCK && !fixing;
			end
			ST_COMPACT: begin
				cmd.shift = holes;
				fin       = !holes;
			end
			ST_PEEL:    fin = pass_q == PASS_W'(N_SLOTS - 1);
			default:    fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			used_q  <= '0;
			ctr_q   <= 32'd1;
			pass_q  <= '0;
			for (int s = 0; s < N_SLOTS; s++) wait_q[s] <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == ST_PEEL) pass_q <= pass_q + 1'b1;
			else pass_q <= '0;
			if (exec) begin
				case (act_q)
					ACT_BEGIN: if (any_free) begin
						used_q[f_idx] <= 1'b1;
						ctr_q         <= ctr_q + 32'd1;
						for (int s = 0; s < N_SLOTS; s++) begin
							if (SLOT_W'(s) == f_idx) wait_q[s] <= '0;
							else wait_q[s][f_idx] <= 1'b0;
						end
					end
					ACT_COMMIT, ACT_ROLLBACK: if (active) wait_q[s_idx] <= '0;
					ACT_ACQUIRE: if (active && conf_any) wait_q[conf_holder][s_idx] <= 1'b1;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			act_q  <= action_t'(action);
			id_q   <= txn_id;
			key_q  <= resource_key;
			excl_q <= lock_exclusive;
		end
		if (state_q == ST_PEEL) alive_q <= alive_nx;
		else alive_q <= '1;
		if (state_q == ST_PEEL && pass_q == PASS_W'(N_SLOTS - 1)) dead_q <= |alive_nx;
		if (exec) begin
			acc_q  <= 1'b0;
			sts_q  <= STS_OK;
			nid_q  <= '0;
			tst_q  <= TS_ACTIVE;
			dead_q <= 1'b0;
			case (act_q)
				ACT_BEGIN: begin
					if (any_free) begin
						sid_q[f_idx] <= ctr_q;
						sst_q[f_idx] <= TS_ACTIVE;
						nid_q        <= ctr_q;
						acc_q        <= 1'b1;
					end else begin
						sts_q <= STS_FULL;
					end
				end
				ACT_COMMIT, ACT_ROLLBACK, ACT_ACQUIRE: begin
					if (!found) sts_q <= STS_NOT_FOUND;
					else if (!active) sts_q <= STS_NOT_ACTIVE;
					else if (act_q == ACT_ACQUIRE) begin
						if (conf_any) sts_q <= STS_CONFLICT;
						else if (full) sts_q <= STS_FULL;
						else acc_q <= 1'b1;
					end else begin
						sst_q[s_idx] <= (act_q == ACT_COMMIT) ? TS_COMMITTED : TS_ABORTED;
						acc_q        <= 1'b1;
					end
				end
				ACT_RELEASE, ACT_DEADLOCK: acc_q <= 1'b1;
				ACT_QUERY: begin
					if (found) begin
						tst_q <= sst_q[s_idx];
						acc_q <= 1'b1;
					end else begin
						sts_q <= STS_NOT_FOUND;
						tst_q <= TS_ABORTED;
					end
				end
				default: ;
			endcase
		end
	end

	assign done       = done_q;
	assign accepted   = acc_q;
	assign status     = sts_q;
	assign new_txn_id = nid_q;
	assign txn_state  = tst_q;
	assign deadlock   = dead_q;
endmodule
`default_nettype wire

// ----- rtl/lmd_cell.sv -----
`default_nettype none
module lmd_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire lmd_pkg::cmd_t   cmd,
	input  wire logic            take_upper,
	input  wire logic            load_here,
	input  wire lmd_pkg::entry_t upper,
	output lmd_pkg::entry_t      q,
	output logic                 conflict
);
	import lmd_pkg::*;

	logic   key_hit;
	logic   drop_me;
	entry_t ent_q;

	assign key_hit  = ent_q.res == cmd.key;
	assign drop_me  = cmd.drop && ent_q.valid && cmd.slot_mask[ent_q.holder]
		&& (!cmd.by_key || key_hit);
	assign conflict = ent_q.valid && key_hit && (ent_q.holder != cmd.slot)
		&& (cmd.excl || ent_q.excl);
	assign q = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (drop_me) begin
			ent_q.valid <= 1'b0;
		end else if (take_upper) begin
			ent_q <= upper;
		end else if (load_here) begin
			ent_q <= entry_t'{1'b1, cmd.key, cmd.slot, cmd.excl};
		end
	end
endmodule
`default_nettype wire

// ----- rtl/lmd_chain.sv -----
`default_nettype none
module lmd_chain (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire lmd_pkg::cmd_t          cmd,
	output logic                        conf_any,
	output logic [lmd_pkg::SLOT_W-1:0]  conf_holder,
	output logic                        full,
	output logic                        holes
);
	import lmd_pkg::*;

	entry_t               q    [N_ENTRIES];
	logic [N_ENTRIES-1:0] v;
	logic [N_ENTRIES-1:0] hole;
	logic [N_ENTRIES-1:0] conf;

	for (genvar i = 0; i < N_ENTRIES; i++) begin : g_cell
		entry_t up;
		logic   load;
		assign v[i] = q[i].valid;
		if (i == 0) begin : g_first
			assign hole[i] = !v[i];
			assign load    = cmd.append && !v[i];
		end else begin : g_rest
			assign hole[i] = hole[i-1] || !v[i];
			assign load    = cmd.append && !v[i] && v[i-1];
		end
		if (i == N_ENTRIES - 1) begin : g_top
			assign up = '0;
		end else begin : g_mid
			assign up = q[i+1];
		end
		lmd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.take_upper (cmd.shift && hole[i]),
			.load_here  (load),
			.upper      (up),
			.q          (q[i]),
			.conflict   (conf[i])
		);
	end

	// A hole is an empty cell with a live entry somewhere above it.
	assign holes = |(~v[N_ENTRIES-2:0] & v[N_ENTRIES-1:1]);
	assign full  = v[N_ENTRIES-1];

	always_comb begin
		conf_any    = 1'b0;
		conf_holder = '0;
		for (int i = N_ENTRIES - 1; i >= 0; i--) begin
			if (conf[i]) begin
				conf_any    = 1'b1;
				conf_holder = q[i].holder;
			end
		end
	end
endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import lmd_pkg::*;

	typedef struct packed {
		logic [2:0]  act;
		logic [31:0] id;
		logic [31:0] key;
		logic        excl;
		logic [7:0]  gap;
	} request_t;

	typedef struct packed {
		logic        acc;
		logic [2:0]  sts;
		logic [31:0] nid;
		logic [1:0]  ts;
		logic        dl;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] action = '0;
	logic [31:0] txn_id = '0;
	logic [31:0] resource_key = '0;
	logic lock_exclusive = 1'b0;
	logic done, accepted, deadlock;
	logic [2:0] status;
	logic [31:0] new_txn_id;
	logic [1:0] txn_state;

	request_t pending_q[$];
	reply_t expected_q[$];
	int mismatches = 0;
	bit stim_done = 1'b0;

	// Shadow of the lock manager's tables.
	bit sh_used[N_SLOTS];
	logic [31:0] sh_id[N_SLOTS];
	logic [1:0] sh_state[N_SLOTS];
	logic [31:0] next_id;
	int n_locks;
	logic [31:0] lk_key[N_ENTRIES];
	int lk_slot[N_ENTRIES];
	bit lk_excl[N_ENTRIES];
	logic [N_SLOTS-1:0] waits_on[N_SLOTS];
	logic [31:0] issued[$];
	logic [31:0] keys[4] = '{32'h0, 32'hFFFFFFFF, 32'h1234_5678, 32'hA5A5_0F0F};

	lock_manager_with_deadlock_check_top DUT (.*);

	always #5 clk = ~clk;

	function automatic int find_slot(logic [31:0] id);
		for (int s = 0; s < N_SLOTS; s++)
			if (sh_used[s] && sh_id[s] == id)
				return s;
		return -1;
	endfunction

	function automatic void squeeze(bit by_key, int slot, logic [31:0] id, logic [31:0] key);
		int w;
		bit drop;
		w = 0;
		for (int r = 0; r < n_locks; r++) begin
			if (!by_key)
				drop = lk_slot[r] == slot;
			else
				drop = lk_key[r] == key && sh_used[lk_slot[r]] && sh_id[lk_slot[r]] == id;
			if (!drop) begin
				lk_key[w] = lk_key[r];
				lk_slot[w] = lk_slot[r];
				lk_excl[w] = lk_excl[r];
				w++;
			end
		end
		n_locks = w;
	endfunction

	function automatic bit wait_cycle();
		logic [N_SLOTS-1:0] alive, incoming;
		alive = '1;
		for (int p = 0; p < N_SLOTS; p++) begin
			incoming = '0;
			for (int s = 0; s < N_SLOTS; s++)
				if (alive[s])
					incoming |= waits_on[s];
			alive &= incoming;
		end
		return alive != 0;
	endfunction

	function automatic reply_t lock_outcome(request_t rq);
		reply_t r;
		int s;
		bit clash;
		r = '0;
		case (action_t'(rq.act))
			ACT_BEGIN: begin
				for (s = 0; s < N_SLOTS; s++)
					if (!sh_used[s] || sh_state[s] != TS_ACTIVE)
						break;
				if (s == N_SLOTS) begin
					r.sts = STS_FULL;
				end else begin
					sh_used[s] = 1'b1;
					sh_id[s] = next_id;
					sh_state[s] = TS_ACTIVE;
					waits_on[s] = '0;
					for (int u = 0; u < N_SLOTS; u++)
						waits_on[u][s] = 1'b0;
					r.nid = next_id;
					issued = {issued, next_id};
					next_id++;
					r.acc = 1'b1;
				end
			end
			ACT_COMMIT, ACT_ROLLBACK: begin
				s = find_slot(rq.id);
				if (s < 0) r.sts = STS_NOT_FOUND;
				else if (sh_state[s] != TS_ACTIVE) r.sts = STS_NOT_ACTIVE;
				else begin
					sh_state[s] = (rq.act == ACT_COMMIT) ? TS_COMMITTED : TS_ABORTED;
					squeeze(1'b0, s, '0, '0);
					waits_on[s] = '0;
					r.acc = 1'b1;
				end
			end
			ACT_ACQUIRE: begin
				s = find_slot(rq.id);
				clash = 1'b0;
				if (s < 0) r.sts = STS_NOT_FOUND;
				else if (sh_state[s] != TS_ACTIVE) r.sts = STS_NOT_ACTIVE;
				else begin
					for (int e = 0; e < n_locks; e++)
						if (lk_key[e] == rq.key && lk_slot[e] != s && (rq.excl || lk_excl[e])) begin
							waits_on[lk_slot[e]][s] = 1'b1;
							clash = 1'b1;
							break;
						end
					if (clash) r.sts = STS_CONFLICT;
					else if (n_locks >= N_ENTRIES) r.sts = STS_FULL;
					else begin
						lk_key[n_locks] = rq.key;
						lk_slot[n_locks] = s;
						lk_excl[n_locks] = rq.excl;
						n_locks++;
						r.acc = 1'b1;
					end
				end
			end
			ACT_RELEASE: begin
				squeeze(1'b1, 0, rq.id, rq.key);
				r.acc = 1'b1;
			end
			ACT_DEADLOCK: begin
				r.dl = wait_cycle();
				r.acc = 1'b1;
			end
			ACT_QUERY: begin
				s = find_slot(rq.id);
				if (s < 0) begin
					r.sts = STS_NOT_FOUND;
					r.ts = TS_ABORTED;
				end else begin
					r.ts = sh_state[s];
					r.acc = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] pick_id();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0 || issued.size() == 0) return $urandom;
		if (k < 7 && issued.size() > 0)
			return issued[issued.size() - 1 - $urandom_range(0, (issued.size() > 6 ? 5 : issued.size() - 1))];
		return issued[$urandom_range(0, issued.size() - 1)];
	endfunction

	task automatic add(logic [2:0] a, logic [31:0] id, logic [31:0] key, int unsigned x);
		request_t rq;
		rq.act = a;
		rq.id = id;
		rq.key = key;
		rq.excl = x[0];
		rq.gap = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 7));
		pending_q = {pending_q, rq};
	endtask

	// Driver: one transfer per accepted start, with a random hold-off before each.
	request_t cur;
	int hold = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				start <= 1'b0;
				expected_q = {expected_q, lock_outcome(cur)};
			end else if (!start) begin
				if (hold > 0) begin
					hold <= hold - 1;
				end else if (pending_q.size() > 0) begin
					cur = pending_q.pop_front();
					if (cur.gap != 0) begin
						hold <= cur.gap - 1;
						pending_q.push_front(cur);
						pending_q[0].gap = 0;
					end else begin
						action <= cur.act;
						txn_id <= cur.id;
						resource_key <= cur.key;
						lock_exclusive <= cur.excl;
						start <= 1'b1;
					end
				end
			end
		end
	end

	// Monitor: every done strobe is one result transfer.
	always @(posedge clk) begin
		reply_t e, got;
		if (arst_n && done) begin
			got = '{accepted, status, new_txn_id, txn_state, deadlock};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer %p", got);
			end else begin
				e = expected_q.pop_front();
				if (got !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", e, got);
				end
			end
		end
	end

	initial begin
		int a;
		for (int s = 0; s < N_SLOTS; s++) begin
			sh_used[s] = 1'b0;
			waits_on[s] = '0;
		end
		next_id = 32'd1;
		n_locks = 0;
		// Directed part: every action, absent ids, conflicts, a deadlock, unused code.
		add(ACT_QUERY, 32'hFFFFFFFF, 0, 0);
		add(ACT_COMMIT, 32'd0, 0, 0);
		add(ACT_ACQUIRE, 32'd5, 0, 1);
		add(ACT_BEGIN, 0, 0, 0);
		add(ACT_BEGIN, 0, 0, 0);
		add(ACT_ACQUIRE, 32'd1, 32'hFFFFFFFF, 1);
		add(ACT_ACQUIRE, 32'd1, 32'hFFFFFFFF, 0);
		add(ACT_ACQUIRE, 32'd2, 32'hFFFFFFFF, 0);
		add(ACT_ACQUIRE, 32'd2, 32'd0, 0);
		add(ACT_ACQUIRE, 32'd1, 32'd0, 0);
		add(ACT_ACQUIRE, 32'd1, 32'd0, 1);
		add(ACT_DEADLOCK, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
		add(ACT_RELEASE, 32'd1, 32'hFFFFFFFF, 0);
		add(ACT_RELEASE, 32'd9, 32'd9, 0);
		add(ACT_COMMIT, 32'd1, 0, 0);
		add(ACT_COMMIT, 32'd1, 0, 0);
		add(ACT_QUERY, 32'd1, 0, 0);
		add(ACT_ROLLBACK, 32'd2, 0, 0);
		add(ACT_QUERY, 32'd2, 0, 0);
		add(ACT_ACQUIRE, 32'd2, 0, 0);
		add(3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
		for (int i = 0; i < 17; i++)
			add(ACT_BEGIN, 0, 0, 0);
		// Random part: acquires most often, mostly on a small key pool, among issued transactions.
		for (int i = 0; i < 520; i++) begin
			a = $urandom_range(0, 99);
			if (a < 10) add(ACT_BEGIN, $urandom, $urandom, $urandom);
			else if (a < 17) add(ACT_COMMIT, pick_id(), $urandom, $urandom);
			else if (a < 24) add(ACT_ROLLBACK, pick_id(), $urandom, $urandom);
			else if (a < 62)
				add(ACT_ACQUIRE, pick_id(),
					($urandom_range(0, 7) == 0) ? $urandom : keys[$urandom_range(0, 3)],
					$urandom);
			else if (a < 74)
				add(ACT_RELEASE, pick_id(),
					($urandom_range(0, 7) == 0) ? $urandom : keys[$urandom_range(0, 3)],
					$urandom);
			else if (a < 86) add(ACT_DEADLOCK, $urandom, $urandom, $urandom);
			else if (a < 97) add(ACT_QUERY, pick_id(), $urandom, $urandom);
			else add(3'd7, $urandom, $urandom, $urandom);
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_q.size() == 0 && !start);
		wait (expected_q.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
